// ----- design/rp2_pkg.sv -----
// Shared package for the relative pose block.
// Holds the sequencer states, the control word for the iterative units,
// and the fixed-point constants and arctangent table. No dependencies.
package rp2_pkg;

    // Fixed-point constants: angles Q3.13, CORDIC Q2.30
    localparam int TABLE_LEN  = 24;
    localparam int ITER_W     = 5;
    localparam int SQRT_STEPS = 17;
    localparam int CORDIC_W   = 34;

    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
    localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
    localparam logic [15:0]        DEG_MUL     = 16'd29335;
    localparam logic [31:0]        CORDIC_GAIN = 32'h26DD3B6A;

    // Command codes carried in the input tuser
    localparam logic CMD_REF    = 1'b0;
    localparam logic CMD_TARGET = 1'b1;

    // Arctangent of 2^-i in Q2.30, truncated
    localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_WRAP,
        S_SQX,
        S_SQY,
        S_DEG,
        S_INIT,
        S_ITER,
        S_DONE
    } rp2_state_t;

    // Control word from the sequencer to the iterative units
    typedef struct packed {
        logic              load;
        logic              step;
        logic [ITER_W-1:0] iter;
    } rp2_ctl_t;

endpackage

// ----- design/rp2_sqrt.sv -----
// Bit-serial integer square root with round-to-nearest, one root bit per step.
// Depends on rp2_pkg for the control word and step count.
module rp2_sqrt (
    input  logic             aclk,
    input  rp2_pkg::rp2_ctl_t ctl,
    input  logic [33:0]      radicand,
    output logic [16:0]      root
);
    import rp2_pkg::*;

    logic [33:0] op_reg;
    logic [18:0] rem_reg;
    logic [16:0] root_reg;
    logic [20:0] rem_sh;
    logic [20:0] trial;
    logic        take;

    // Bring down the next two radicand bits and try the next root bit
    assign rem_sh = {rem_reg[18:0], op_reg[33:32]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            op_reg   <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (ctl.step && (ctl.iter < ITER_W'(SQRT_STEPS))) begin
            op_reg <= {op_reg[31:0], 2'b00};
            if (take) begin
                rem_reg  <= 19'(rem_sh - trial);
                root_reg <= {root_reg[15:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[18:0];
                root_reg <= {root_reg[15:0], 1'b0};
            end
        end
    end

    // Remainder is s - r*r; round up when it exceeds r
    assign root = (rem_reg > {2'b00, root_reg}) ? 17'(root_reg + 17'd1) : root_reg;

endmodule

// ----- design/rp2_cordic.sv -----
// Rotation-mode CORDIC, one micro-rotation per step, giving cosine and sine.
// Depends on rp2_pkg for the arctangent table, gain and control word.
module rp2_cordic #(
    parameter int CORDIC_ITERS = 16
) (
    input  logic                aclk,
    input  rp2_pkg::rp2_ctl_t   ctl,
    input  logic signed [15:0]  angle,
    output logic signed [15:0]  cosine,
    output logic signed [15:0]  sine
);
    import rp2_pkg::*;

    localparam int ITERS = (CORDIC_ITERS > TABLE_LEN) ? TABLE_LEN : CORDIC_ITERS;

    logic signed [CORDIC_W-1:0] x_reg, y_reg, z_reg;
    logic                       neg_reg;
    logic signed [16:0]         ang_e;
    logic signed [16:0]         ang_f;
    logic                       ang_neg;
    logic signed [CORDIC_W-1:0] dx, dy, atan_v;
    logic signed [CORDIC_W-1:0] x_rnd, y_rnd;

    function automatic logic signed [15:0] fix_out(input logic signed [17:0] q,
                                                   input logic neg);
        logic signed [18:0] v;
        begin
            v = neg ? -{q[17], q} : {q[17], q};
            if (v > 19'sd16384)
                fix_out = 16'sd16384;
            else if (v < -19'sd16384)
                fix_out = -16'sd16384;
            else
                fix_out = v[15:0];
        end
    endfunction

    // Fold the angle into [-pi/2, pi/2]; results negated when folded
    always_comb begin
        ang_e   = {angle[15], angle};
        ang_f   = ang_e;
        ang_neg = 1'b0;
        if (ang_e > HALF_PI_Q13) begin
            ang_f   = 17'(ang_e - PI_Q13[16:0]);
            ang_neg = 1'b1;
        end else if (ang_e < -HALF_PI_Q13) begin
            ang_f   = 17'(ang_e + PI_Q13[16:0]);
            ang_neg = 1'b1;
        end
    end

    // Shared shifter and adders for one micro-rotation
    assign dx     = y_reg >>> ctl.iter;
    assign dy     = x_reg >>> ctl.iter;
    assign atan_v = {2'b00, ATAN_TAB[ctl.iter]};

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            x_reg   <= CORDIC_W'(CORDIC_GAIN);
            y_reg   <= '0;
            z_reg   <= {ang_f, 17'b0};
            neg_reg <= ang_neg;
        end else if (ctl.step && (ctl.iter < ITER_W'(ITERS))) begin
            if (!z_reg[CORDIC_W-1]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_v;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_v;
            end
        end
    end

    // Round Q4.30 to Q2.14, restore sign, clamp to +-1.0
    assign x_rnd  = x_reg + CORDIC_W'(32768);
    assign y_rnd  = y_reg + CORDIC_W'(32768);
    assign cosine = fix_out(x_rnd[CORDIC_W-1:16], neg_reg);
    assign sine   = fix_out(y_rnd[CORDIC_W-1:16], neg_reg);

endmodule

// ----- design/relative_pose_2d_top.sv -----
// Relative pose of a target body to a reference body in the plane.
// Reference update: stores the reference pose, no result; s_tready stays high.
// Target update: the sequencer runs DIFF, WRAP, SQX, SQY, DEG and INIT, then
// the shared square-root and CORDIC iteration loop, and waits in DONE until
// the output register can be loaded; s_tready rises with m_tvalid (one target at a time).
// Reset (aresetn low, synchronous) clears the reference pose and the sequencer.
module relative_pose_2d_top #(
    parameter int CORDIC_ITERS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // pos_x[15:0], pos_y[31:16], heading[47:32]
    input  logic [0:0]   s_tuser,   // cmd[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // offset_x[16:0], offset_y[33:17], distance[50:34], angle_rad[66:51],
    // angle_deg[81:67], cosine[97:82], sine[113:98], zero fill above
    output logic [119:0] m_tdata
);
    import rp2_pkg::*;

    localparam int NSTEPS = (CORDIC_ITERS > SQRT_STEPS) ? CORDIC_ITERS : SQRT_STEPS;

    rp2_state_t state_reg, state_next;
    rp2_ctl_t   ctl;

    logic [ITER_W-1:0] cnt_reg;
    logic [15:0]  ref_x_reg, ref_y_reg;
    logic signed [15:0] ref_h_reg;
    logic [15:0]  px_reg, py_reg;
    logic signed [15:0] h_reg;
    logic signed [16:0] tx_reg, ty_reg, diff_reg;
    logic signed [15:0] angle_reg;
    logic         angle_neg_reg;
    logic [14:0]  amag_reg;
    logic [15:0]  ax_reg, ay_reg;
    logic [31:0]  prod_reg;
    logic [33:0]  sum_reg;
    logic signed [14:0] deg_reg;
    logic         m_tvalid_reg;
    logic [119:0] m_tdata_reg;

    logic         s_xfer, load_out;
    logic signed [17:0] wrap_v;
    logic [15:0]  mul_a, mul_b;
    logic [32:0]  deg_rnd;
    logic [14:0]  deg_mag;
    logic [16:0]  root_v;
    logic signed [15:0] cos_v, sin_v;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign load_out = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and unit control
    always_comb begin
        state_next = state_reg;
        ctl.load   = 1'b0;
        ctl.step   = 1'b0;
        ctl.iter   = cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer && (s_tuser[0] == CMD_TARGET))
                    state_next = S_DIFF;
            end
            S_DIFF: state_next = S_WRAP;
            S_WRAP: state_next = S_SQX;
            S_SQX:  state_next = S_SQY;
            S_SQY:  state_next = S_DEG;
            S_DEG:  state_next = S_INIT;
            S_INIT: begin
                ctl.load   = 1'b1;
                state_next = S_ITER;
            end
            S_ITER: begin
                ctl.step = 1'b1;
                if (cnt_reg == ITER_W'(NSTEPS - 1))
                    state_next = S_DONE;
            end
            S_DONE: begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Iteration counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (state_reg == S_ITER) begin
            cnt_reg <= ITER_W'(cnt_reg + 1'b1);
        end else begin
            cnt_reg <= '0;
        end
    end

    // Reference pose
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
            ref_h_reg <= '0;
        end else if (s_xfer && (s_tuser[0] == CMD_REF)) begin
            ref_x_reg <= s_tdata[15:0];
            ref_y_reg <= s_tdata[31:16];
            ref_h_reg <= s_tdata[47:32];
        end
    end

    // Heading difference wrapped once by 2*pi
    always_comb begin
        wrap_v = {diff_reg[16], diff_reg};
        if (wrap_v > PI_Q13)
            wrap_v = wrap_v - TWO_PI_Q13;
        else if (wrap_v < -PI_Q13)
            wrap_v = wrap_v + TWO_PI_Q13;
    end

    // Shared multiplier operand select
    always_comb begin
        unique case (state_reg)
            S_SQY:   begin mul_a = ay_reg;           mul_b = ay_reg;  end
            S_DEG:   begin mul_a = {1'b0, amag_reg}; mul_b = DEG_MUL; end
            default: begin mul_a = ax_reg;           mul_b = ax_reg;  end
        endcase
    end

    // Degrees: round half up on the magnitude, then restore sign
    assign deg_rnd = {1'b0, prod_reg} + 33'd32768;
    assign deg_mag = deg_rnd[30:16];

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            px_reg <= s_tdata[15:0];
            py_reg <= s_tdata[31:16];
            h_reg  <= s_tdata[47:32];
        end
        if (state_reg == S_DIFF) begin
            tx_reg   <= 17'({1'b0, px_reg} - {1'b0, ref_x_reg});
            ty_reg   <= 17'({1'b0, py_reg} - {1'b0, ref_y_reg});
            diff_reg <= 17'({h_reg[15], h_reg} - {ref_h_reg[15], ref_h_reg});
        end
        if (state_reg == S_WRAP) begin
            angle_reg     <= wrap_v[15:0];
            angle_neg_reg <= wrap_v[17];
            amag_reg      <= wrap_v[17] ? 15'(-wrap_v) : wrap_v[14:0];
            ax_reg        <= tx_reg[16] ? 16'(-tx_reg) : tx_reg[15:0];
            ay_reg        <= ty_reg[16] ? 16'(-ty_reg) : ty_reg[15:0];
        end
        if (state_reg == S_SQX || state_reg == S_SQY || state_reg == S_DEG)
            prod_reg <= mul_a * mul_b;
        if (state_reg == S_SQY)
            sum_reg <= {2'b00, prod_reg};
        if (state_reg == S_DEG)
            sum_reg <= sum_reg + {2'b00, prod_reg};
        if (state_reg == S_INIT)
            deg_reg <= angle_neg_reg ? 15'(-deg_mag) : deg_mag;
    end

    rp2_sqrt u_sqrt (
        .aclk     (aclk),
        .ctl      (ctl),
        .radicand (sum_reg),
        .root     (root_v)
    );

    rp2_cordic #(
        .CORDIC_ITERS (CORDIC_ITERS)
    ) u_cordic (
        .aclk   (aclk),
        .ctl    (ctl),
        .angle  (angle_reg),
        .cosine (cos_v),
        .sine   (sin_v)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out)
            m_tdata_reg <= {6'b0, sin_v, cos_v, deg_reg, angle_reg, root_v, ty_reg, tx_reg};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- design/rp2_checker.sv -----
// Port-level checks for relative_pose_2d_top, attached by bind.
// Sees only the top-level ports; no package dependency.
module rp2_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [0:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata
);

    // A stalled result holds its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A target transfer occupies the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
        else $error("input taken while a target is in work");

    // A reference transfer leaves the block ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[0] |=> s_tready)
        else $error("reference update stalled the input");

    // Cosine and sine stay within +-1.0
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[97:82]) <= 16'sd16384)
                  && ($signed(m_tdata[97:82]) >= -16'sd16384)
                  && ($signed(m_tdata[113:98]) <= 16'sd16384)
                  && ($signed(m_tdata[113:98]) >= -16'sd16384))
        else $error("cosine or sine out of range");

    // Wrapped angle stays within +-pi
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[66:51]) <= 16'sd25736)
                  && ($signed(m_tdata[66:51]) >= -16'sd25736))
        else $error("angle not wrapped");

endmodule

bind relative_pose_2d_top rp2_checker u_rp2_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
